>>> sv/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared widths, constants and types for the moving average servo mapper.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int WINDOW      = 20;
  localparam int SAMPLE_BITS = 12;

  localparam int MIN_BITS   = 14;
  localparam int SPAN_BITS  = 14;
  localparam int LIMIT_BITS = 15;
  localparam int PULSE_BITS = 15;
  localparam int ZONE_BITS  = 2;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 15;

  localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_MIN  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_SPAN = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ZONE_LOW   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ZONE_HIGH  = 3'd3;

  localparam logic [MIN_BITS-1:0]   RST_PULSE_MIN  = 14'd1000;
  localparam logic [SPAN_BITS-1:0]  RST_PULSE_SPAN = 14'd1000;
  localparam logic [LIMIT_BITS-1:0] RST_ZONE_LOW   = 15'd1365;
  localparam logic [LIMIT_BITS-1:0] RST_ZONE_HIGH  = 15'd1730;

  localparam logic [PULSE_BITS-1:0] PULSE_CEIL = 15'd20000;

  localparam logic [ZONE_BITS-1:0] ZONE_LOW  = 2'd0;
  localparam logic [ZONE_BITS-1:0] ZONE_MID  = 2'd1;
  localparam logic [ZONE_BITS-1:0] ZONE_HIGH = 2'd2;

  localparam longint unsigned FULL_SCALE = (64'd1 << SAMPLE_BITS) - 64'd1;

  // window sum and divide-by-window reciprocal
  localparam int SUM_BITS = $clog2(WINDOW * FULL_SCALE + 1);
  localparam int K1       = SUM_BITS + $clog2(WINDOW);
  localparam longint unsigned RECIP1 = ((64'd1 << K1) + WINDOW - 1) / WINDOW;
  localparam int R1_BITS  = $clog2(RECIP1 + 1);
  localparam int PR1_BITS = SUM_BITS + R1_BITS;

  // avg * span and divide-by-full-scale reciprocal
  localparam int P_BITS   = SAMPLE_BITS + SPAN_BITS;
  localparam int K2       = P_BITS + $clog2(FULL_SCALE);
  localparam longint unsigned RECIP2 = ((64'd1 << K2) + FULL_SCALE - 1) / FULL_SCALE;
  localparam int R2_BITS  = $clog2(RECIP2 + 1);
  localparam int PR2_BITS = P_BITS + R2_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [MIN_BITS-1:0]   pulse_min;
    logic [SPAN_BITS-1:0]  pulse_span;
    logic [LIMIT_BITS-1:0] zone_low;
    logic [LIMIT_BITS-1:0] zone_high;
  } cfg_t;

endpackage

>>> sv/msp_if.sv
// ----------------------------------------------------------------------------
// msp_if
// Valid/ready channels: sample in, result out, configuration write.
// ----------------------------------------------------------------------------
interface msp_sample_if import msp_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface msp_result_if import msp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PULSE_BITS-1:0] pulse_width;
  logic [ZONE_BITS-1:0]  zone;
  sample_t               average;

  modport source (output valid, output pulse_width, output zone, output average,
                  input ready);
  modport sink   (input valid, input pulse_width, input zone, input average,
                  output ready);
endinterface

interface msp_cfg_if import msp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/msp_cell.sv
// ----------------------------------------------------------------------------
// msp_cell
// One window slot: holds a sample, loads its neighbor's sample on shift.
// ----------------------------------------------------------------------------
module msp_cell import msp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    shift,
  input  sample_t d_in,
  output sample_t q
);

  sample_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

>>> sv/msp_map.sv
// ----------------------------------------------------------------------------
// msp_map
// Running window sum, mean, pulse mapping and zone, five registered stages.
// ----------------------------------------------------------------------------
module msp_map import msp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sample_t               sample,
  input  sample_t               oldest,
  input  cfg_t                  cfg,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PULSE_BITS-1:0] pulse_width,
  output logic [ZONE_BITS-1:0]  zone,
  output sample_t               average
);

  logic [SUM_BITS-1:0] sum_r, sum_nxt;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [SUM_BITS-1:0]   s1_sum_r;
  logic [PR1_BITS-1:0]   prod1_r;
  sample_t               avg3_r, avg4_r, avg5_r;
  logic [P_BITS-1:0]     prod2_r;
  logic [PR2_BITS-1:0]   prod3_r;
  logic [PULSE_BITS-1:0] pulse_r;
  logic [ZONE_BITS-1:0]  zone_r;

  sample_t               avg3;
  logic [SPAN_BITS-1:0]  quot;
  logic [PULSE_BITS-1:0] mapped, pulse_sat;
  logic [ZONE_BITS-1:0]  zone_c;

  assign rdy5 = !v5_r || out_ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign sum_nxt = sum_r + SUM_BITS'(sample) - SUM_BITS'(oldest);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
    end else begin
      if (in_valid && rdy1) sum_r <= sum_nxt;
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  assign avg3 = prod1_r[K1 +: SAMPLE_BITS];
  assign quot = prod3_r[K2 +: SPAN_BITS];
  assign mapped = PULSE_BITS'(cfg.pulse_min) + PULSE_BITS'(quot);
  assign pulse_sat = (mapped > PULSE_CEIL) ? PULSE_CEIL : mapped;

  always_comb begin
    if (pulse_sat < cfg.zone_low) begin
      zone_c = ZONE_LOW;
    end else if (pulse_sat < cfg.zone_high) begin
      zone_c = ZONE_MID;
    end else begin
      zone_c = ZONE_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_sum_r <= sum_nxt;
    if (rdy2) prod1_r <= PR1_BITS'(s1_sum_r) * PR1_BITS'(RECIP1);
    if (rdy3) begin
      avg3_r  <= avg3;
      prod2_r <= P_BITS'(avg3) * P_BITS'(cfg.pulse_span);
    end
    if (rdy4) begin
      avg4_r  <= avg3_r;
      prod3_r <= PR2_BITS'(prod2_r) * PR2_BITS'(RECIP2);
    end
    if (rdy5) begin
      avg5_r  <= avg4_r;
      pulse_r <= pulse_sat;
      zone_r  <= zone_c;
    end
  end

  assign out_valid   = v5_r;
  assign pulse_width = pulse_r;
  assign zone        = zone_r;
  assign average     = avg5_r;

endmodule

>>> sv/moving_average_servo_pulse_mapper.sv
// ----------------------------------------------------------------------------
// moving_average_servo_pulse_mapper
// Boxcar average of joystick samples mapped to a servo pulse width and zone.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one 12-bit converter sample per item.
//   out_ch : one result per sample: pulse_width (us), zone, average.
//   cfg_ch : register writes (pulse_min, pulse_span, zone limits), always
//            ready; write only while no item is in flight.
// The window is a chain of WINDOW sample cells that shifts on each accepted
// item; a running sum drops the sample leaving the last cell.
// Pipeline: five register stages: sum, mean multiply, span multiply, scale
// multiply, saturate/zone.
// Throughput: one item per cycle, sustained while out_ch does not stall.
// Stall: a waiting result holds on out_ch; the stages behind it keep
// filling and in_ch.ready drops only once all five stages are occupied.
// Reset: window cells, sum and pipeline valid flags are cleared, registers
// return to their defaults, so the first averages count zeros.
// ----------------------------------------------------------------------------
module moving_average_servo_pulse_mapper import msp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  msp_sample_if.sink   in_ch,
  msp_result_if.source out_ch,
  msp_cfg_if.sink      cfg_ch
);

  cfg_t    cfg_r;
  logic    shift;
  sample_t chain [WINDOW+1];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_min  <= RST_PULSE_MIN;
      cfg_r.pulse_span <= RST_PULSE_SPAN;
      cfg_r.zone_low   <= RST_ZONE_LOW;
      cfg_r.zone_high  <= RST_ZONE_HIGH;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_PULSE_MIN:  cfg_r.pulse_min  <= cfg_ch.data[MIN_BITS-1:0];
        REG_PULSE_SPAN: cfg_r.pulse_span <= cfg_ch.data[SPAN_BITS-1:0];
        REG_ZONE_LOW:   cfg_r.zone_low   <= cfg_ch.data[LIMIT_BITS-1:0];
        REG_ZONE_HIGH:  cfg_r.zone_high  <= cfg_ch.data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign shift    = in_ch.valid && in_ch.ready;
  assign chain[0] = in_ch.sample;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    msp_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (shift),
      .d_in  (chain[i]),
      .q     (chain[i+1])
    );
  end

  msp_map u_map (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .sample      (in_ch.sample),
    .oldest      (chain[WINDOW]),
    .cfg         (cfg_r),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .pulse_width (out_ch.pulse_width),
    .zone        (out_ch.zone),
    .average     (out_ch.average)
  );

endmodule

>>> sv/msp_checker.sv
// ----------------------------------------------------------------------------
// msp_checker
// Port-level checks on the servo mapper result channel.
// ----------------------------------------------------------------------------
module msp_checker import msp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PULSE_BITS-1:0] pulse_width,
  input logic [ZONE_BITS-1:0]  zone,
  input sample_t               average
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pulse_width) &&
    $stable(zone) && $stable(average))
    else $error("result changed while stalled");

  a_ceil: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pulse_width <= PULSE_CEIL)
    else $error("pulse width above ceiling");

  a_zone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> zone == ZONE_LOW || zone == ZONE_MID || zone == ZONE_HIGH)
    else $error("bad zone code");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind moving_average_servo_pulse_mapper msp_checker u_msp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pulse_width (out_ch.pulse_width),
  .zone        (out_ch.zone),
  .average     (out_ch.average)
);

>>> dv/tb_moving_average_servo_pulse_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_average_servo_pulse_mapper
// Drives converter samples through the boxcar servo mapper under random
// stalls on both channels. A tracker keeps its own copy of the sample window
// and registers, predicts pulse width, zone and average for every accepted
// item, and compares each result in order. Register settings change between
// phases while the block is idle: defaults, saturation, zero span, crossed
// limits, unknown indexes and random values.
// ----------------------------------------------------------------------------
import msp_pkg::*;

typedef struct packed {
  logic [PULSE_BITS-1:0] pulse_width;
  logic [ZONE_BITS-1:0]  zone;
  sample_t               average;
} pulse_result_t;

class pulse_map_tracker;
  sample_t               window_cells[WINDOW];
  int unsigned           oldest;
  logic [SUM_BITS-1:0]   running_sum;
  cfg_t                  regs;
  pulse_result_t         expected_pulses[$];
  int                    errors;

  function new();
    foreach (window_cells[i]) window_cells[i] = '0;
    oldest          = 0;
    running_sum     = '0;
    regs.pulse_min  = RST_PULSE_MIN;
    regs.pulse_span = RST_PULSE_SPAN;
    regs.zone_low   = RST_ZONE_LOW;
    regs.zone_high  = RST_ZONE_HIGH;
    errors          = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
    case (idx)
      REG_PULSE_MIN:  regs.pulse_min  = d[MIN_BITS-1:0];
      REG_PULSE_SPAN: regs.pulse_span = d[SPAN_BITS-1:0];
      REG_ZONE_LOW:   regs.zone_low   = d[LIMIT_BITS-1:0];
      REG_ZONE_HIGH:  regs.zone_high  = d[LIMIT_BITS-1:0];
      default: ;
    endcase
  endfunction

  function void note_sample(sample_t s);
    longint unsigned mean;
    longint unsigned mapped;
    pulse_result_t   r;
    running_sum = running_sum - SUM_BITS'(window_cells[oldest]) + SUM_BITS'(s);
    window_cells[oldest] = s;
    oldest = (oldest == WINDOW - 1) ? 0 : oldest + 1;
    mean = longint'(running_sum) / WINDOW;
    mapped = longint'(regs.pulse_min) + (mean * longint'(regs.pulse_span)) / FULL_SCALE;
    if (mapped > PULSE_CEIL) mapped = 64'(PULSE_CEIL);
    r.pulse_width = mapped[PULSE_BITS-1:0];
    r.average     = mean[SAMPLE_BITS-1:0];
    if (r.pulse_width < regs.zone_low) r.zone = ZONE_LOW;
    else if (r.pulse_width < regs.zone_high) r.zone = ZONE_MID;
    else r.zone = ZONE_HIGH;
    expected_pulses.push_back(r);
  endfunction

  function void check_result(logic [PULSE_BITS-1:0] pw, logic [ZONE_BITS-1:0] z,
                             sample_t avg);
    pulse_result_t e;
    if (expected_pulses.size() == 0) begin
      $error("unexpected result: pulse_width %0d zone %0d average %0d", pw, z, avg);
      errors++;
      return;
    end
    e = expected_pulses.pop_front();
    if (pw !== e.pulse_width) begin
      $error("pulse_width: expected %0d, actual %0d", e.pulse_width, pw);
      errors++;
    end
    if (z !== e.zone) begin
      $error("zone: expected %0d, actual %0d", e.zone, z);
      errors++;
    end
    if (avg !== e.average) begin
      $error("average: expected %0d, actual %0d", e.average, avg);
      errors++;
    end
  endfunction

  function int pending();
    return expected_pulses.size();
  endfunction
endclass

module tb_moving_average_servo_pulse_mapper;

  logic clk;
  logic rst_n;

  int tx_idle_pct = 22;
  int rx_idle_pct = 22;
  bit hold_req    = 1'b0;
  int hold_left   = 0;

  pulse_map_tracker pulse_track = new();

  msp_sample_if in_if ();
  msp_result_if out_if ();
  msp_cfg_if    cfg_if ();

  moving_average_servo_pulse_mapper DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: ready pattern plus long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 80;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      pulse_track.check_result(out_if.pulse_width, out_if.zone, out_if.average);
  end

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk); while (!in_if.ready);
    pulse_track.note_sample(s);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pulse_track.pending() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    pulse_track.write_reg(idx, d);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_BITS-1:0] pmin, pspan, lo, hi);
    write_reg(REG_PULSE_MIN, pmin);
    write_reg(REG_PULSE_SPAN, pspan);
    write_reg(REG_ZONE_LOW, lo);
    write_reg(REG_ZONE_HIGH, hi);
  endtask

  task automatic random_config();
    logic [CFG_DATA_BITS-1:0] pmin;
    logic [CFG_DATA_BITS-1:0] pspan;
    logic [CFG_DATA_BITS-1:0] lo;
    logic [CFG_DATA_BITS-1:0] hi;
    if ($urandom_range(1)) begin
      pmin  = CFG_DATA_BITS'($urandom_range(2**CFG_DATA_BITS - 1));
      pspan = CFG_DATA_BITS'($urandom_range(2**CFG_DATA_BITS - 1));
      lo    = CFG_DATA_BITS'($urandom_range(2**CFG_DATA_BITS - 1));
      hi    = CFG_DATA_BITS'($urandom_range(2**CFG_DATA_BITS - 1));
    end else begin
      pmin  = CFG_DATA_BITS'($urandom_range(10000));
      pspan = CFG_DATA_BITS'($urandom_range(10000));
      lo    = CFG_DATA_BITS'($urandom_range(20000));
      hi    = CFG_DATA_BITS'($urandom_range(20000));
    end
    set_config(pmin, pspan, lo, hi);
  endtask

  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return sample_t'($urandom_range(2**SAMPLE_BITS - 1));
  endfunction

  // runs of random or constant samples so the average also reaches its ends
  task automatic run_samples(input int count);
    int      n;
    int      len;
    bit      steady;
    sample_t v;
    n = 0;
    while (n < count) begin
      len    = $urandom_range(1, 30);
      steady = ($urandom_range(9) < 4);
      v      = pick_sample();
      for (int k = 0; k < len && n < count; k++) begin
        send_sample(steady ? v : pick_sample());
        n++;
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // start-up with default registers: zeros still in the window
    send_sample('0);
    send_sample('1);
    send_sample(12'hAAA);
    send_sample(12'h555);
    repeat (WINDOW) send_sample('1);
    send_sample('0);
    run_samples(250);
    wait_idle();

    // saturation, with masking of wide register values
    set_config('1, '1, 15'd20000, '1);
    run_samples(120);
    wait_idle();

    set_config('0, '0, '0, '0);
    run_samples(80);
    wait_idle();

    // crossed limits, then writes to unused indexes that must change nothing
    set_config(15'd0, 15'd10000, 15'd1500, 15'd800);
    for (int i = REG_ZONE_HIGH + 1; i < 2**CFG_IDX_BITS; i++)
      write_reg(i[CFG_IDX_BITS-1:0],
                CFG_DATA_BITS'($urandom_range(2**CFG_DATA_BITS - 1)));
    run_samples(200);
    wait_idle();

    // no idling on either side
    set_config(CFG_DATA_BITS'(RST_PULSE_MIN), CFG_DATA_BITS'(RST_PULSE_SPAN),
               CFG_DATA_BITS'(RST_ZONE_LOW), CFG_DATA_BITS'(RST_ZONE_HIGH));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_samples(250);
    wait_idle();

    // result side holds off while samples keep coming
    set_config(15'd5000, 15'd10000, 15'd8000, 15'd12000);
    hold_req = 1'b1;
    run_samples(200);
    wait_idle();
    tx_idle_pct = 22;
    rx_idle_pct = 22;

    repeat (4) begin
      random_config();
      run_samples(200);
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (pulse_track.errors == 0 && pulse_track.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
